// ===== hdl/gma_pkg.sv =====
// ----------------------------------------------------------------------------
// gma_pkg
// Shared types and constants of the greedy matching arbiter.
// ----------------------------------------------------------------------------
package gma_pkg;

   localparam int HOST_COUNT    = 16;
   localparam int PENDING_DEPTH = 32;
   localparam int RANK_BITS     = 16;

   localparam int HOST_W  = $clog2(HOST_COUNT);
   localparam int PEND_W  = $clog2(PENDING_DEPTH);
   localparam int LEN_W   = $clog2(HOST_COUNT + 1);
   localparam int COUNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int DRAW_W  = $clog2(HOST_COUNT * RANK_BITS);
   localparam int RBIT_W  = $clog2(RANK_BITS);

   localparam logic [15:0] LFSR_MASK      = 16'hB400;
   localparam logic [15:0] SEED_RESET     = 16'd1;
   localparam logic [15:0] INTERVAL_RESET = 16'd100;

   typedef enum logic [1:0] {
      KIND_ELEMENT = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_TICK    = 2'd2,
      KIND_SPARE   = 2'd3
   } kind_type;

   typedef enum logic {
      REG_SEED     = 1'b0,
      REG_INTERVAL = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_DRAW,
      ST_IDLE,
      ST_COMMIT,
      ST_SCAN,
      ST_CHECK,
      ST_WALK,
      ST_PUSH,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [HOST_W-1:0] dest;
      logic [LEN_W-1:0]  len;
   } info_type;

endpackage

// ===== hdl/gma_if.sv =====
// ----------------------------------------------------------------------------
// gma_if
// Request and result channels of the greedy matching arbiter.
// ----------------------------------------------------------------------------
interface gma_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [3:0] dst_id;
   logic [3:0] src_id;
   logic       list_end;

   modport source (output valid, kind, dst_id, src_id, list_end, input ready);
   modport sink (input valid, kind, dst_id, src_id, list_end, output ready);
endinterface

interface gma_rsp_if;
   logic       valid;
   logic       ready;
   logic       grant_valid;
   logic [3:0] grant_src;
   logic [3:0] grant_dst;
   logic       run_end;
   logic       overflow;

   modport source (output valid, grant_valid, grant_src, grant_dst, run_end, overflow,
                   input ready);
   modport sink (input valid, grant_valid, grant_src, grant_dst, run_end, overflow,
                 output ready);
endinterface

// ===== hdl/greedy_matching_arbiter.sv =====
// ----------------------------------------------------------------------------
// greedy_matching_arbiter
// Central matcher that pairs sources with destinations once per epoch.
// ----------------------------------------------------------------------------
// The req channel carries three kinds of request. A list element adds one
// source to the request being built (the destination comes from the first
// element, the list closes on list_end); a release frees one source and one
// destination; an epoch tick serves all pending requests. Only a tick gives
// results on the rsp channel: one per grant, the last one marked run_end, or
// a single empty result marked run_end when nothing was granted.
// A closing element copies the 16-entry build buffer into the source memory.
// A tick with n pending requests runs n+1 rank scans through the request
// memory; each scan whose best request has a free destination walks that
// request's source list up to its first free source, and each grant then
// passes a push step. Ranks are redrawn one LFSR bit per cycle after reset,
// after a seed write and every interval_ff epochs; no request is taken then.
// Reset frees all hosts, empties the pending set and starts the rank draw.
// The result sits in an output register; while the receiver stalls, the
// matcher halts when it must pass on a held grant or the closing result,
// and the req channel stays closed until the epoch has finished.
module greedy_matching_arbiter (
   input  logic                 clock,
   input  logic                 reset,
   gma_req_if.sink              req,
   gma_rsp_if.source            rsp,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import gma_pkg::*;

   state_type state_ff, state_in;

   // Configuration.
   logic [15:0] seed_ff;
   logic [15:0] interval_ff;
   logic        cfg_wr;
   logic        seed_wr;

   // Rank generator and rank table.
   logic [15:0]          lfsr_ff;
   logic [RANK_BITS-2:0] racc_ff;
   logic [DRAW_W-1:0]    draw_cnt_ff;
   logic [RANK_BITS-1:0] rank_ff [HOST_COUNT];
   logic                 lfsr_bit;
   logic [15:0]          lfsr_step;

   // Host maps and counters.
   logic [HOST_COUNT-1:0] src_free_ff;
   logic [HOST_COUNT-1:0] dst_free_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [15:0]          epoch_ff;
   logic [16:0]          epoch_next;
   logic                 ovf_ff;

   // Build buffer.
   logic              bld_open_ff;
   logic              bld_drop_ff;
   logic [HOST_W-1:0] bld_dest_ff;
   logic [LEN_W-1:0]  bld_len_ff;
   logic [HOST_W-1:0] bld_src_ff [HOST_COUNT];
   logic [HOST_W-1:0] copy_ff;

   // Pending request memories.
   info_type              info_mem [PENDING_DEPTH];
   logic [HOST_W-1:0]     src_mem  [PENDING_DEPTH*HOST_COUNT];
   info_type              info_rd_ff;
   logic [HOST_W-1:0]     src_rd_ff;
   logic                  info_we;
   logic [PEND_W-1:0]     info_waddr;
   logic [PEND_W-1:0]     info_raddr;
   logic                  src_we;
   logic [PEND_W+HOST_W-1:0] src_waddr;
   logic [PEND_W+HOST_W-1:0] src_raddr;

   // Epoch engine.
   logic [PENDING_DEPTH-1:0] served_ff;
   logic [COUNT_W-1:0]       scan_idx_ff;
   logic                     rd_v_ff;
   logic [PEND_W-1:0]        rd_idx_ff;
   logic                     best_v_ff;
   logic [PEND_W-1:0]        best_idx_ff;
   logic [RANK_BITS-1:0]     best_rank_ff;
   info_type                 best_info_ff;
   logic [LEN_W-1:0]         walk_j_ff;
   logic                     wrd_v_ff;
   logic [HOST_W-1:0]        new_src_ff;
   logic                     hold_v_ff;
   logic [HOST_W-1:0]        hold_src_ff;
   logic [HOST_W-1:0]        hold_dst_ff;
   logic                     scan_issue;
   logic                     walk_issue;
   logic                     slot_free;
   logic                     better;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_gv_ff;
   logic [HOST_W-1:0] rsp_src_ff;
   logic [HOST_W-1:0] rsp_dst_ff;
   logic              rsp_end_ff;
   logic              rsp_ovf_ff;

   logic req_fire;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign seed_wr    = cfg_wr && (csr_paddr[2] == REG_SEED);

   always_comb begin
      case (csr_paddr[2])
         REG_SEED:     csr_prdata = {16'd0, seed_ff};
         REG_INTERVAL: csr_prdata = {16'd0, interval_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.grant_valid = rsp_gv_ff;
   assign rsp.grant_src   = rsp_src_ff;
   assign rsp.grant_dst   = rsp_dst_ff;
   assign rsp.run_end     = rsp_end_ff;
   assign rsp.overflow    = rsp_ovf_ff;

   assign slot_free = !rsp_valid_ff || rsp.ready;

   assign lfsr_bit  = lfsr_ff[0];
   assign lfsr_step = (lfsr_ff >> 1) ^ (lfsr_bit ? LFSR_MASK : 16'd0);

   assign epoch_next = {1'b0, epoch_ff} + 17'd1;

   assign scan_issue = (state_ff == ST_SCAN) && (scan_idx_ff < count_ff);
   assign walk_issue = (state_ff == ST_WALK) && (walk_j_ff < best_info_ff.len);

   // A candidate wins only on a strictly lower rank, so ties go to arrival.
   assign better = rd_v_ff && !served_ff[rd_idx_ff] &&
                   (!best_v_ff || (rank_ff[info_rd_ff.dest] < best_rank_ff));

   // Memory addressing.
   assign info_we    = (state_ff == ST_COMMIT) && (copy_ff == '0);
   assign info_waddr = count_ff[PEND_W-1:0];
   assign info_raddr = scan_idx_ff[PEND_W-1:0];
   assign src_we     = (state_ff == ST_COMMIT);
   assign src_waddr  = {count_ff[PEND_W-1:0], copy_ff};
   assign src_raddr  = {best_idx_ff, walk_j_ff[HOST_W-1:0]};

   always_ff @(posedge clock) begin
      if (info_we) begin
         info_mem[info_waddr] <= '{dest: bld_dest_ff, len: bld_len_ff};
      end
      info_rd_ff <= info_mem[info_raddr];
      if (src_we) begin
         src_mem[src_waddr] <= bld_src_ff[copy_ff];
      end
      src_rd_ff <= src_mem[src_raddr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_DRAW: begin
            if (draw_cnt_ff == DRAW_W'(HOST_COUNT * RANK_BITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req.kind == KIND_TICK) begin
                  state_in = ST_SCAN;
               end else if (req.kind == KIND_ELEMENT && req.list_end &&
                            !(bld_open_ff ? bld_drop_ff
                                          : (count_ff >= COUNT_W'(PENDING_DEPTH)))) begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_COMMIT: begin
            if (copy_ff == HOST_W'(HOST_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!scan_issue && !rd_v_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!best_v_ff) begin
               state_in = ST_FINAL;
            end else if (dst_free_ff[best_info_ff.dest] && best_info_ff.len != '0) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_WALK: begin
            if (wrd_v_ff && src_free_ff[src_rd_ff]) begin
               state_in = ST_PUSH;
            end else if (!walk_issue && !wrd_v_ff) begin
               state_in = ST_SCAN;
            end
         end
         ST_PUSH: begin
            if (!hold_v_ff || slot_free) begin
               state_in = ST_SCAN;
            end
         end
         ST_FINAL: begin
            if (slot_free) begin
               state_in = (epoch_next[15:0] >= interval_ff) ? ST_DRAW : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (seed_wr) begin
         state_in = ST_DRAW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DRAW;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_RESET;
         interval_ff  <= INTERVAL_RESET;
         lfsr_ff      <= SEED_RESET;
         draw_cnt_ff  <= '0;
         src_free_ff  <= '1;
         dst_free_ff  <= '1;
         count_ff     <= '0;
         epoch_ff     <= '0;
         ovf_ff       <= 1'b0;
         bld_open_ff  <= 1'b0;
         bld_drop_ff  <= 1'b0;
         bld_len_ff   <= '0;
         copy_ff      <= '0;
         served_ff    <= '0;
         scan_idx_ff  <= '0;
         rd_v_ff      <= 1'b0;
         best_v_ff    <= 1'b0;
         walk_j_ff    <= '0;
         wrd_v_ff     <= 1'b0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_DRAW: begin
               lfsr_ff     <= lfsr_step;
               racc_ff     <= {racc_ff[RANK_BITS-3:0], lfsr_bit};
               draw_cnt_ff <= draw_cnt_ff + DRAW_W'(1);
               if (draw_cnt_ff[RBIT_W-1:0] == RBIT_W'(RANK_BITS - 1)) begin
                  rank_ff[draw_cnt_ff[DRAW_W-1:RBIT_W]] <= {racc_ff, lfsr_bit};
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req.kind)
                     KIND_ELEMENT: begin
                        logic drop;
                        logic [LEN_W-1:0] len;
                        drop = bld_open_ff ? bld_drop_ff
                                           : (count_ff >= COUNT_W'(PENDING_DEPTH));
                        len  = bld_open_ff ? bld_len_ff : '0;
                        if (!bld_open_ff) begin
                           bld_dest_ff <= req.dst_id;
                           if (drop) begin
                              ovf_ff <= 1'b1;
                           end
                        end
                        bld_open_ff <= !req.list_end || !drop;
                        bld_drop_ff <= drop && !req.list_end;
                        bld_len_ff  <= len;
                        if (!drop) begin
                           if (len < LEN_W'(HOST_COUNT)) begin
                              bld_src_ff[len[HOST_W-1:0]] <= req.src_id;
                              bld_len_ff <= len + LEN_W'(1);
                           end else begin
                              ovf_ff <= 1'b1;
                           end
                        end
                        copy_ff <= '0;
                     end
                     KIND_RELEASE: begin
                        src_free_ff[req.src_id] <= 1'b1;
                        dst_free_ff[req.dst_id] <= 1'b1;
                     end
                     KIND_TICK: begin
                        served_ff   <= '0;
                        hold_v_ff   <= 1'b0;
                        scan_idx_ff <= '0;
                        rd_v_ff     <= 1'b0;
                        best_v_ff   <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_COMMIT: begin
               copy_ff <= copy_ff + HOST_W'(1);
               if (copy_ff == HOST_W'(HOST_COUNT - 1)) begin
                  count_ff    <= count_ff + COUNT_W'(1);
                  bld_open_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               rd_v_ff   <= scan_issue;
               rd_idx_ff <= scan_idx_ff[PEND_W-1:0];
               if (scan_issue) begin
                  scan_idx_ff <= scan_idx_ff + COUNT_W'(1);
               end
               if (better) begin
                  best_v_ff    <= 1'b1;
                  best_idx_ff  <= rd_idx_ff;
                  best_rank_ff <= rank_ff[info_rd_ff.dest];
                  best_info_ff <= info_rd_ff;
               end
            end
            ST_CHECK: begin
               walk_j_ff   <= '0;
               wrd_v_ff    <= 1'b0;
               scan_idx_ff <= '0;
               rd_v_ff     <= 1'b0;
               if (best_v_ff) begin
                  served_ff[best_idx_ff] <= 1'b1;
               end
               if (!(dst_free_ff[best_info_ff.dest] && best_info_ff.len != '0)) begin
                  best_v_ff <= 1'b0;
               end
            end
            ST_WALK: begin
               wrd_v_ff <= walk_issue;
               if (walk_issue) begin
                  walk_j_ff <= walk_j_ff + LEN_W'(1);
               end
               if (wrd_v_ff && src_free_ff[src_rd_ff]) begin
                  src_free_ff[src_rd_ff]         <= 1'b0;
                  dst_free_ff[best_info_ff.dest] <= 1'b0;
                  new_src_ff                     <= src_rd_ff;
               end else if (!walk_issue && !wrd_v_ff) begin
                  best_v_ff <= 1'b0;
               end
            end
            ST_PUSH: begin
               if (!hold_v_ff || slot_free) begin
                  if (hold_v_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_gv_ff    <= 1'b1;
                     rsp_src_ff   <= hold_src_ff;
                     rsp_dst_ff   <= hold_dst_ff;
                     rsp_end_ff   <= 1'b0;
                     rsp_ovf_ff   <= ovf_ff;
                  end
                  hold_v_ff   <= 1'b1;
                  hold_src_ff <= new_src_ff;
                  hold_dst_ff <= best_info_ff.dest;
                  best_v_ff   <= 1'b0;
               end
            end
            ST_FINAL: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_gv_ff    <= hold_v_ff;
                  rsp_src_ff   <= hold_v_ff ? hold_src_ff : '0;
                  rsp_dst_ff   <= hold_v_ff ? hold_dst_ff : '0;
                  rsp_end_ff   <= 1'b1;
                  rsp_ovf_ff   <= ovf_ff;
                  hold_v_ff    <= 1'b0;
                  count_ff     <= '0;
                  draw_cnt_ff  <= '0;
                  if (epoch_next[15:0] >= interval_ff) begin
                     epoch_ff <= '0;
                  end else begin
                     epoch_ff <= epoch_next[15:0];
                  end
               end
            end
            default: ;
         endcase

         // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
         if (cfg_wr) begin
            unique case (csr_paddr[2])
               REG_SEED: begin
                  seed_ff     <= csr_pwdata[15:0];
                  lfsr_ff     <= (csr_pwdata[15:0] == 16'd0) ? 16'd1 : csr_pwdata[15:0];
                  draw_cnt_ff <= '0;
               end
               REG_INTERVAL: interval_ff <= csr_pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

`ifndef NO_ASSERTIONS
   // The pending count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(PENDING_DEPTH))
      else $error("pending count beyond depth");

   // A held grant never survives the end of its epoch.
   a_hold_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_v_ff)
      else $error("grant held outside an epoch");

   // A grant taken from the list marks both hosts busy on the next cycle.
   a_grant_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && wrd_v_ff && src_free_ff[src_rd_ff] && !seed_wr) |=>
      (!src_free_ff[new_src_ff] && !dst_free_ff[best_info_ff.dest]))
      else $error("granted hosts not marked busy");
`endif

endmodule
